@@ rtl/core/bsaw_pkg.sv @@
// ----------------------------------------------------------------------------
// bsaw_pkg
// Shared widths and register codes for the bilinear sample address unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsaw_pkg;

	localparam int PIX_W    = 10;
	localparam int BIAS_W   = PIX_W + 2;
	localparam int SCALE_W  = 3;
	localparam int DIMREG_W = 11;
	localparam int ADDR_W   = 20;
	localparam int WT_W     = 6;
	localparam int CASE_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 96;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_LOG2 = 2'd0,
		REG_MAP_WIDTH  = 2'd1,
		REG_MAP_HEIGHT = 2'd2
	} cfg_reg_t;

	localparam logic [DIMREG_W-1:0] DIM_RESET = 11'd1024;

endpackage

`default_nettype wire

@@ rtl/core/bilinear_sample_address_weights_unit.sv @@
// ----------------------------------------------------------------------------
// bilinear_sample_address_weights_unit
// Maps a full-resolution pixel onto a power-of-two downsampled feature map
// and gives the blend case, four plane addresses and two weights in 64ths.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pixel_row, pixel_col
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser: blend_case; tdata: addrs,
//                                               weights
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
//  One item per cycle while m_axis is not stalled; an input is captured in the
//  input register, and its result in the result register after the multiply-add
//  path, from which it is offered.
//  Reset clears both valid flags and loads the register defaults.
//  A stall on m_axis holds the result; the input register still fills, and
//  s_axis_tready drops only when both stages are held.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_sample_address_weights_unit #(
	parameter int MAP_DIM_MAX    = 1024,
	parameter int IMAGE_DIM_MAX  = 1024,
	parameter int MAX_SCALE_LOG2 = 5
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [9:0] pixel_row, [19:10] pixel_col, [23:20] zero
	input  wire logic [bsaw_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [19:0] addr_top_left, [39:20] addr_top_right, [59:40] addr_bottom_left,
	// [79:60] addr_bottom_right, [85:80] weight_col, [91:86] weight_row,
	// [95:92] zero
	output logic [bsaw_pkg::M_TDATA_W-1:0]           m_axis_tdata,
	// [1:0] blend_case
	output logic [bsaw_pkg::CASE_W-1:0]              m_axis_tuser,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bsaw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bsaw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import bsaw_pkg::*;

	localparam int DW    = $clog2(MAP_DIM_MAX + 1);
	localparam int FW    = (MAP_DIM_MAX > 2) ? $clog2(MAP_DIM_MAX) : 1;
	localparam int CW    = (DW > BIAS_W) ? DW + 1 : BIAS_W + 1;
	localparam int SUM_W = FW + DW + 2;
	localparam int REM_W = 8;
	localparam int WSH_W = REM_W + WT_W;

	typedef struct packed {
		logic [FW-1:0]   lo;
		logic            pair;
		logic [WT_W-1:0] wt;
	} axis_res_t;

	// configuration
	logic [SCALE_W-1:0]  scale_log2_q;
	logic [DIMREG_W-1:0] map_width_q;
	logic [DIMREG_W-1:0] map_height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_log2_q <= '0;
			map_width_q  <= DIM_RESET;
			map_height_q <= DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SCALE_LOG2: scale_log2_q <= cfg_data[SCALE_W-1:0];
				REG_MAP_WIDTH:  map_width_q  <= cfg_data[DIMREG_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= cfg_data[DIMREG_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SCALE_W-1:0] k_eff;
	logic [DW-1:0]      w_eff;
	logic [DW-1:0]      h_eff;

	function automatic logic [DW-1:0] clamp_dim(input logic [DIMREG_W-1:0] v);
		logic [31:0] v32;
		v32 = 32'(v);
		if (v32 == 32'd0)
			return DW'(1);
		else if (v32 > 32'(MAP_DIM_MAX))
			return DW'(MAP_DIM_MAX);
		else
			return DW'(v32);
	endfunction

	always_comb begin
		if (32'(scale_log2_q) > 32'(MAX_SCALE_LOG2))
			k_eff = SCALE_W'(MAX_SCALE_LOG2);
		else
			k_eff = scale_log2_q;
		w_eff = clamp_dim(map_width_q);
		h_eff = clamp_dim(map_height_q);
	end

	function automatic axis_res_t axis_map(input logic [PIX_W-1:0] p,
			input logic [SCALE_W-1:0] k, input logic [DW-1:0] dim);
		logic [PIX_W-1:0]  ps;
		logic [BIAS_W-1:0] s;
		logic [BIAS_W-1:0] biased;
		logic [BIAS_W-1:0] msk;
		logic [BIAS_W-1:0] q;
		logic [REM_W-1:0]  rem;
		logic [CW-1:0]     qx;
		logic [CW-1:0]     dx;
		logic [WSH_W-1:0]  wsh;
		axis_res_t         r;
		if (32'(p) > 32'(IMAGE_DIM_MAX - 1))
			ps = PIX_W'(IMAGE_DIM_MAX - 1);
		else
			ps = p;
		s      = BIAS_W'(1) << k;
		biased = {1'b0, ps, 1'b1} + s;
		msk    = (s << 1) - BIAS_W'(1);
		rem    = REM_W'(biased & msk);
		q      = biased >> (k + SCALE_W'(1));
		qx     = CW'(q);
		dx     = CW'(dim);
		if (q == '0)
			r.lo = '0;
		else if (qx > dx)
			r.lo = FW'(dx - CW'(1));
		else
			r.lo = FW'(qx - CW'(1));
		r.pair = (q != '0) && (rem != '0) && (qx < dx);
		wsh    = {rem, {WT_W{1'b0}}} >> (k + SCALE_W'(1));
		r.wt   = r.pair ? wsh[WT_W-1:0] : '0;
		return r;
	endfunction

	// stage 1: input register
	logic              valid_s1;
	logic [PIX_W-1:0]  row_s1;
	logic [PIX_W-1:0]  col_s1;
	logic              out_valid_q;
	logic              adv_out;

	assign adv_out       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			row_s1 <= s_axis_tdata[PIX_W-1:0];
			col_s1 <= s_axis_tdata[2*PIX_W-1:PIX_W];
		end
	end

	// address and weight path
	axis_res_t          ax_c;
	axis_res_t          ax_r;
	logic [FW+DW-1:0]   prod;
	logic [SUM_W-1:0]   tl_full;
	logic [SUM_W-1:0]   tr_full;
	logic [SUM_W-1:0]   bl_full;
	logic [SUM_W-1:0]   br_full;

	always_comb begin
		ax_c    = axis_map(col_s1, k_eff, w_eff);
		ax_r    = axis_map(row_s1, k_eff, h_eff);
		prod    = (FW+DW)'(ax_r.lo) * (FW+DW)'(w_eff);
		tl_full = SUM_W'(prod) + SUM_W'(ax_c.lo);
		tr_full = tl_full + SUM_W'(ax_c.pair);
		bl_full = ax_r.pair ? tl_full + SUM_W'(w_eff) : tl_full;
		br_full = bl_full + SUM_W'(ax_c.pair);
	end

	// stage 2: result register
	logic [CASE_W-1:0] case_q;
	logic [ADDR_W-1:0] tl_q;
	logic [ADDR_W-1:0] tr_q;
	logic [ADDR_W-1:0] bl_q;
	logic [ADDR_W-1:0] br_q;
	logic [WT_W-1:0]   wc_q;
	logic [WT_W-1:0]   wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			case_q <= {ax_r.pair, ax_c.pair};
			tl_q   <= ADDR_W'(tl_full);
			tr_q   <= ADDR_W'(tr_full);
			bl_q   <= ADDR_W'(bl_full);
			br_q   <= ADDR_W'(br_full);
			wc_q   <= ax_c.wt;
			wr_q   <= ax_r.wt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = case_q;
	assign m_axis_tdata  = {
		(M_TDATA_W - 4*ADDR_W - 2*WT_W)'(0), wr_q, wc_q, br_q, bl_q, tr_q, tl_q
	};

endmodule

`default_nettype wire

@@ dv/sample_address_checker.sv @@
// ----------------------------------------------------------------------------
// sample_address_checker
// Watches the config, pixel and result channels of the bilinear sample
// address unit. Keeps its own copy of the registers, predicts the blend case,
// the four plane addresses and both weights for every accepted pixel, and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sample_address_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	input  wire logic                            s_axis_tready,
	input  wire logic [bsaw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic                            m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	input  wire logic [bsaw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  wire logic [bsaw_pkg::CASE_W-1:0]     m_axis_tuser,
	input  wire logic                            cfg_valid,
	input  wire logic                            cfg_ready,
	input  wire logic [bsaw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bsaw_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                   n_fail,
	output int                                   n_pending
);
	import bsaw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_DIM_MAX    = 1024;
	localparam int IMAGE_DIM_MAX  = 1024;
	localparam int MAX_SCALE_LOG2 = 5;

	typedef struct packed {
		logic [CASE_W-1:0] blend_case;
		logic [ADDR_W-1:0] top_left;
		logic [ADDR_W-1:0] top_right;
		logic [ADDR_W-1:0] bottom_left;
		logic [ADDR_W-1:0] bottom_right;
		logic [WT_W-1:0]   weight_col;
		logic [WT_W-1:0]   weight_row;
	} sample_t;

	logic [SCALE_W-1:0]  scale_reg;
	logic [DIMREG_W-1:0] width_reg;
	logic [DIMREG_W-1:0] height_reg;
	sample_t             expected_samples[$];
	int                  fails = 0;

	function automatic int clamp_dim(input int v);
		if (v < 1)
			return 1;
		if (v > MAP_DIM_MAX)
			return MAP_DIM_MAX;
		return v;
	endfunction

	// position on one axis in units of 1/(2s), biased by 2s to stay positive
	function automatic void axis_fold(input int p, input int k, input int dim,
			output int lo, output bit pair, output int wt);
		int s;
		int biased;
		int rem;
		int fl;
		int ce;
		s = 1 << k;
		if (p > IMAGE_DIM_MAX - 1)
			p = IMAGE_DIM_MAX - 1;
		biased = 2 * p + 1 + s;
		rem = biased & (2 * s - 1);
		fl = (biased >> (k + 1)) - 1;
		ce = fl + ((rem != 0) ? 1 : 0);
		if (fl < 0)
			fl = 0;
		if (ce < 0)
			ce = 0;
		if (fl > dim - 1)
			fl = dim - 1;
		if (ce >= dim)
			ce = fl;
		lo = fl;
		pair = (ce != fl);
		wt = pair ? (((rem * 64) >> (k + 1)) & 63) : 0;
	endfunction

	function automatic sample_t predict_sample(input logic [PIX_W-1:0] row,
			input logic [PIX_W-1:0] col);
		int k;
		int w;
		int h;
		int fr;
		int fc;
		int wr;
		int wc;
		int tl;
		int tr;
		int bl;
		int br;
		bit vr;
		bit hc;
		sample_t r;
		k = scale_reg;
		if (k > MAX_SCALE_LOG2)
			k = MAX_SCALE_LOG2;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		axis_fold(col, k, w, fc, hc, wc);
		axis_fold(row, k, h, fr, vr, wr);
		tl = fr * w + fc;
		tr = hc ? tl + 1 : tl;
		bl = vr ? tl + w : tl;
		br = vr ? tr + w : tr;
		r.blend_case   = {vr, hc};
		r.top_left     = ADDR_W'(tl);
		r.top_right    = ADDR_W'(tr);
		r.bottom_left  = ADDR_W'(bl);
		r.bottom_right = ADDR_W'(br);
		r.weight_col   = WT_W'(wc);
		r.weight_row   = WT_W'(wr);
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sample_t seen;
		sample_t want;
		if (!arst_n) begin
			scale_reg  <= '0;
			width_reg  <= DIM_RESET;
			height_reg <= DIM_RESET;
			expected_samples.delete();
			n_pending  <= 0;
			n_fail     <= fails;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCALE_LOG2: scale_reg  <= cfg_data[SCALE_W-1:0];
					REG_MAP_WIDTH:  width_reg  <= cfg_data;
					REG_MAP_HEIGHT: height_reg <= cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_samples.insert(expected_samples.size(),
					predict_sample(s_axis_tdata[PIX_W-1:0],
					s_axis_tdata[2*PIX_W-1:PIX_W]));
			if (m_axis_tvalid && m_axis_tready) begin
				seen.blend_case   = m_axis_tuser;
				seen.top_left     = m_axis_tdata[ADDR_W-1:0];
				seen.top_right    = m_axis_tdata[2*ADDR_W-1:ADDR_W];
				seen.bottom_left  = m_axis_tdata[3*ADDR_W-1:2*ADDR_W];
				seen.bottom_right = m_axis_tdata[4*ADDR_W-1:3*ADDR_W];
				seen.weight_col   = m_axis_tdata[4*ADDR_W+WT_W-1:4*ADDR_W];
				seen.weight_row   = m_axis_tdata[4*ADDR_W+2*WT_W-1:4*ADDR_W+WT_W];
				if (expected_samples.size() == 0) begin
					$error("unexpected result transfer: tuser=%0d tdata=%h",
						m_axis_tuser, m_axis_tdata);
					fails++;
				end else begin
					want = expected_samples.pop_front();
					check_field("blend_case", want.blend_case, seen.blend_case);
					check_field("addr_top_left", want.top_left, seen.top_left);
					check_field("addr_top_right", want.top_right, seen.top_right);
					check_field("addr_bottom_left", want.bottom_left, seen.bottom_left);
					check_field("addr_bottom_right", want.bottom_right,
						seen.bottom_right);
					check_field("weight_col", want.weight_col, seen.weight_col);
					check_field("weight_row", want.weight_row, seen.weight_row);
				end
			end
			n_pending <= expected_samples.size();
			n_fail    <= fails;
		end
	end

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the bilinear sample address unit: a directed set of pixels over
// edge configurations, then random register settings with random pixels,
// most of them aimed inside the mapped area. Both stream sides idle in
// random bursts, the output side holds off once for a long stretch, and the
// last phase runs at full rate. The checker gives the failure count.
// ----------------------------------------------------------------------------
module testbench;
	import bsaw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 200;
	localparam int RAND_PHASES  = 14;
	localparam int PHASE_ITEMS  = 75;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic [CASE_W-1:0]     m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    n_fail;
	int                    n_pending;

	int cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	bit long_hold_req = 1'b0;

	bilinear_sample_address_weights_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	sample_address_checker i_checker (.*);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold_req = 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// only between phases, once every pending result has left
	task automatic configure(input logic [CFG_DATA_W-1:0] scale_data,
			input logic [CFG_DATA_W-1:0] width_data,
			input logic [CFG_DATA_W-1:0] height_data, input bit poke_unused);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_SCALE_LOG2, scale_data);
		write_reg(REG_MAP_WIDTH, width_data);
		write_reg(REG_MAP_HEIGHT, height_data);
		if (poke_unused)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 2047)));
		cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
		if ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {col, row};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic int pick_dim();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 2;
			3: return 1024;
			4: return $urandom_range(1025, 2047);
			5: return $urandom_range(0, 2047);
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	// mostly within reach of the mapped area, sometimes anywhere
	function automatic logic [PIX_W-1:0] pick_pixel(input int dim, input int k);
		int reach;
		reach = (dim << k) + (1 << k);
		if (reach > 1023 || $urandom_range(0, 9) < 3)
			reach = 1023;
		return PIX_W'($urandom_range(0, reach));
	endfunction

	initial begin
		int scale_v;
		int width_v;
		int height_v;
		int k_eff;
		int w_eff;
		int h_eff;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_SCALE_LOG2;
		cfg_data      = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight after reset
		push_pixel(0, 0);
		push_pixel(1023, 1023);
		push_pixel(0, 1023);
		push_pixel(1023, 0);
		push_pixel(10'h2AA, 10'h155);
		push_pixel(10'h155, 10'h2AA);

		// small map, pixels with no blend and with blend on both axes
		configure(1, 4, 4, 1'b1);
		push_pixel(0, 0);
		push_pixel(1, 2);
		push_pixel(2, 1);
		push_pixel(3, 3);
		push_pixel(7, 7);
		push_pixel(1023, 1023);

		// scale saturates, zero width, oversize height
		configure(11'h7FF, 0, 2047, 1'b0);
		push_pixel(0, 0);
		push_pixel(40, 40);
		push_pixel(1023, 1023);
		push_pixel(500, 17);

		configure(5, 1025, 1, 1'b1);
		push_pixel(16, 48);
		push_pixel(1023, 0);
		push_pixel(33, 1000);

		configure(6, 3, 1024, 1'b0);
		push_pixel(4, 5);
		push_pixel(1023, 9);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0) begin
				scale_v  = 5;
				width_v  = 1024;
				height_v = 1024;
			end else if (ph == 1) begin
				scale_v  = 0;
				width_v  = 1;
				height_v = 1;
			end else begin
				scale_v  = ($urandom_range(0, 255) << 3) | $urandom_range(0, 7);
				width_v  = pick_dim();
				height_v = pick_dim();
			end
			configure(CFG_DATA_W'(scale_v), CFG_DATA_W'(width_v), CFG_DATA_W'(height_v),
				$urandom_range(0, 3) == 0);
			case (ph % 4)
				0: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct   = 30;
					stall_pct = 30;
				end
				2: begin
					gap_pct   = 10;
					stall_pct = 50;
				end
				default: begin
					gap_pct   = 50;
					stall_pct = 10;
				end
			endcase
			if (ph == 2) begin
				gap_pct       = 0;
				long_hold_req = 1'b1;
			end
			if (ph == RAND_PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			k_eff = scale_v & 7;
			if (k_eff > 5)
				k_eff = 5;
			w_eff = (width_v & 2047) < 1 ? 1 :
				((width_v & 2047) > 1024 ? 1024 : (width_v & 2047));
			h_eff = (height_v & 2047) < 1 ? 1 :
				((height_v & 2047) > 1024 ? 1024 : (height_v & 2047));
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_pixel(pick_pixel(h_eff, k_eff), pick_pixel(w_eff, k_eff));
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_fail == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ bilinear_sample_address_weights_unit.f @@
rtl/core/bsaw_pkg.sv
rtl/core/bilinear_sample_address_weights_unit.sv
dv/sample_address_checker.sv
dv/testbench.sv
